[sv/hidtus_pkg.sv]
// Shared types and constants for the HID descriptor top-level usage scan.
// No dependencies; imported by hidtus_scan and hid_descriptor_top_usage_scan.
`default_nettype none

package hidtus_pkg;

  // Result codes carried on the status port.
  typedef enum logic [1:0] {
    STATUS_FOUND = 2'd0,
    STATUS_LONG  = 2'd1,
    STATUS_NONE  = 2'd2
  } status_e;

  // Prefix byte that opens a long item.
  localparam logic [7:0]  LONG_ITEM_PREFIX = 8'hFE;

  // Short item size code that stands for four data bytes.
  localparam logic [1:0]  SIZE_CODE_FOUR   = 2'd3;

  // Item tags, prefix bits 7..2.
  localparam logic [5:0]  TAG_USAGE_PAGE   = 6'h01;  // prefix 0x04
  localparam logic [5:0]  TAG_USAGE        = 6'h02;  // prefix 0x08
  localparam logic [5:0]  TAG_COLLECTION   = 6'h28;  // prefix 0xA0

  localparam logic [31:0] COLL_APPLICATION = 32'h0000_0001;

  localparam logic [15:0] PAGE_DESKTOP     = 16'h0001;
  localparam logic [15:0] PAGE_VENDOR      = 16'hFF00;
  localparam logic [15:0] USAGE_JOYSTICK   = 16'h0004;
  localparam logic [15:0] USAGE_GAMEPAD    = 16'h0005;

  // One result of the scan, produced with the byte that decides it.
  typedef struct packed {
    logic        valid;
    status_e     status;
    logic [15:0] page;
    logic [15:0] usage;
    logic        admitted;
  } scan_result_t;

endpackage

`default_nettype wire

[sv/hidtus_scan.sv]
// Short item parser state and per-byte decode for the top-level usage scan.
// Depends on hidtus_pkg for tags, status codes and the result struct.
`default_nettype none

module hidtus_scan
  import hidtus_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         step_i,
  input  wire logic [7:0]   desc_byte_i,
  input  wire logic         last_byte_i,
  input  wire logic         vendor_mode_i,
  output scan_result_t      result_o
);

  logic [15:0] page_q, page_d;
  logic [15:0] usage_q, usage_d;
  logic        usage_seen_q, usage_seen_d;
  logic [5:0]  item_tag_q, item_tag_d;
  logic [2:0]  bytes_left_q, bytes_left_d;
  logic [1:0]  byte_pos_q, byte_pos_d;
  logic [31:0] data_accum_q, data_accum_d;
  logic        decided_q, decided_d;

  logic        finish;
  logic [5:0]  fin_tag;
  logic [31:0] fin_data;
  logic        found;
  logic [2:0]  item_size;
  logic [31:0] byte_shifted;

  always_comb begin
    item_size    = (desc_byte_i[1:0] == SIZE_CODE_FOUR) ? 3'd4 : {1'b0, desc_byte_i[1:0]};
    byte_shifted = {24'd0, desc_byte_i} << {byte_pos_q, 3'b000};

    page_d       = page_q;
    usage_d      = usage_q;
    usage_seen_d = usage_seen_q;
    item_tag_d   = item_tag_q;
    bytes_left_d = bytes_left_q;
    byte_pos_d   = byte_pos_q;
    data_accum_d = data_accum_q;
    decided_d    = decided_q;

    finish   = 1'b0;
    fin_tag  = item_tag_q;
    fin_data = data_accum_q;
    found    = 1'b0;

    result_o          = '0;
    result_o.status   = STATUS_NONE;

    if (!decided_q) begin
      if (bytes_left_q == 3'd0) begin
        if (desc_byte_i == LONG_ITEM_PREFIX) begin
          result_o.valid  = 1'b1;
          result_o.status = STATUS_LONG;
          decided_d       = 1'b1;
        end else begin
          item_tag_d   = desc_byte_i[7:2];
          data_accum_d = '0;
          byte_pos_d   = 2'd0;
          bytes_left_d = item_size;
          finish       = (item_size == 3'd0);
          fin_tag      = desc_byte_i[7:2];
          fin_data     = '0;
        end
      end else begin
        data_accum_d = data_accum_q | byte_shifted;
        byte_pos_d   = byte_pos_q + 2'd1;
        bytes_left_d = bytes_left_q - 3'd1;
        finish       = (bytes_left_q == 3'd1);
        fin_data     = data_accum_d;
      end

      if (finish) begin
        if (fin_tag == TAG_USAGE_PAGE) begin
          page_d = fin_data[15:0];
        end else if (fin_tag == TAG_USAGE) begin
          if (!usage_seen_q) begin
            usage_d      = fin_data[15:0];
            usage_seen_d = 1'b1;
          end
        end else if (fin_tag == TAG_COLLECTION) begin
          found = (fin_data == COLL_APPLICATION);
        end
      end

      // A collection item leaves page and usage untouched, so the held values apply.
      if (found) begin
        result_o.valid  = 1'b1;
        result_o.status = STATUS_FOUND;
        result_o.page   = page_q;
        result_o.usage  = usage_q;
        if (vendor_mode_i) begin
          result_o.admitted = (page_q == PAGE_VENDOR);
        end else begin
          result_o.admitted = (page_q == PAGE_DESKTOP) &&
                              ((usage_q == USAGE_GAMEPAD) || (usage_q == USAGE_JOYSTICK));
        end
        decided_d = 1'b1;
      end

      if (last_byte_i && !decided_d) begin
        result_o          = '0;
        result_o.valid    = 1'b1;
        result_o.status   = STATUS_NONE;
      end
    end

    // The final byte always starts a fresh scan for the next descriptor.
    if (last_byte_i) begin
      page_d       = '0;
      usage_d      = '0;
      usage_seen_d = 1'b0;
      item_tag_d   = '0;
      bytes_left_d = '0;
      byte_pos_d   = '0;
      data_accum_d = '0;
      decided_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_q       <= '0;
      usage_q      <= '0;
      usage_seen_q <= 1'b0;
      item_tag_q   <= '0;
      bytes_left_q <= '0;
      byte_pos_q   <= '0;
      data_accum_q <= '0;
      decided_q    <= 1'b0;
    end else if (step_i) begin
      page_q       <= page_d;
      usage_q      <= usage_d;
      usage_seen_q <= usage_seen_d;
      item_tag_q   <= item_tag_d;
      bytes_left_q <= bytes_left_d;
      byte_pos_q   <= byte_pos_d;
      data_accum_q <= data_accum_d;
      decided_q    <= decided_d;
    end
  end

endmodule

`default_nettype wire

[sv/hid_descriptor_top_usage_scan.sv]
// Top level of the HID report descriptor top-level usage scan.
// Depends on hidtus_pkg and instantiates hidtus_scan.
//
//   channel   direction  handshake             payload
//   ---------------------------------------------------------------------------
//   in        into       in_valid_i/in_stall_o desc_byte_i, last_byte_i
//   out       out of     out_valid_o/out_stall_i status_o, top_page_o, top_usage_o,
//                                              admitted_o
//   cfg       into       cfg_valid_i/cfg_ready_o cfg_data_i (vendor mode)
//
// One descriptor byte is taken per cycle while the output is not stalled. A beat is held in
// the input register, is decoded by the item parser, and its result (if any) is written to
// the output register as the beat leaves the input register and out_valid_o then rises.
// Reset clears the parser, the vendor mode bit and both valid flags; there is no
// clearing pass. While a result waits on a stalled output the parser holds, and the
// input register fills and then stalls the input side.
`default_nettype none

module hid_descriptor_top_usage_scan
  import hidtus_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,

  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  input  wire logic [7:0]   desc_byte_i,
  input  wire logic         last_byte_i,

  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output logic [1:0]        status_o,
  output logic [15:0]       top_page_o,
  output logic [15:0]       top_usage_o,
  output logic              admitted_o,

  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic         cfg_data_i
);

  logic         vendor_mode_q;

  logic         stg_valid_q;
  logic [7:0]   stg_byte_q;
  logic         stg_last_q;

  logic         out_valid_q;
  scan_result_t res_q;
  scan_result_t scan_res;

  logic         out_free;
  logic         advance;
  logic         in_take;

  // The output register can take a new value when it is empty or being drained.
  assign out_free = !out_valid_q || !out_stall_i;
  // A staged beat is decoded only when its result has a place to go.
  assign advance  = stg_valid_q && out_free;
  assign in_stall_o = stg_valid_q && !out_free;
  assign in_take  = in_valid_i && !in_stall_o;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vendor_mode_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      vendor_mode_q <= cfg_data_i;
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else if (in_take) begin
      stg_valid_q <= 1'b1;
    end else if (advance) begin
      stg_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      stg_byte_q <= desc_byte_i;
      stg_last_q <= last_byte_i;
    end
  end

  hidtus_scan u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (advance),
    .desc_byte_i   (stg_byte_q),
    .last_byte_i   (stg_last_q),
    .vendor_mode_i (vendor_mode_q),
    .result_o      (scan_res)
  );

  // Result register. Bytes that produce no result leave it empty.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance && scan_res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      res_q <= scan_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = res_q.status;
  assign top_page_o  = res_q.page;
  assign top_usage_o = res_q.usage;
  assign admitted_o  = res_q.admitted;

endmodule

`default_nettype wire
